[rtl/view_cone_nearest_target_pick_unit_defines.svh]
// ----------------------------------------------------------------------------
// View cone target pick: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VIEW_CONE_NEAREST_TARGET_PICK_UNIT_DEFINES_SVH
`define VIEW_CONE_NEAREST_TARGET_PICK_UNIT_DEFINES_SVH

// Same-cycle implication.
`define VCNTP_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("view cone pick: assertion failed");

// Next-cycle implication.
`define VCNTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("view cone pick: assertion failed");

`endif

[rtl/vcntp_pkg.sv]
// ----------------------------------------------------------------------------
// View cone target pick package
// Widths, constants and shared types of the view cone target pick block.
// ----------------------------------------------------------------------------
package vcntp_pkg;

  localparam int POS_W        = 21;
  localparam int DIR_W        = 16;
  localparam int NUM_W        = 10;
  localparam int CFG_IDX_W    = 3;
  localparam int ENTITY_COUNT = 1024;
  localparam int COUNT_CMP_W  = 13;

  localparam int DELTA_W  = POS_W + 1;
  localparam int SQ_W     = 2 * DELTA_W - 1;
  localparam int DIST_W   = SQ_W + 1;
  localparam int PROD_W   = DELTA_W + DIR_W;
  localparam int FWD_W    = PROD_W + 2;
  localparam int FRAC_W   = 14;
  localparam int FWD4_W   = FWD_W - 2 - FRAC_W;
  localparam int FSQ_W    = 2 * FWD4_W;
  localparam int LAT_W    = DIST_W;
  localparam int LAT100_W = DIST_W + 7;

  localparam int NEAR_LIMIT = 256;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int TDATA_W = 80;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EYE_X = 3'd0,
    CFG_EYE_Y = 3'd1,
    CFG_EYE_Z = 3'd2,
    CFG_DIR_X = 3'd3,
    CFG_DIR_Y = 3'd4,
    CFG_DIR_Z = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [POS_W-1:0] eye_x;
    logic [POS_W-1:0] eye_y;
    logic [POS_W-1:0] eye_z;
    logic [DIR_W-1:0] dir_x;
    logic [DIR_W-1:0] dir_y;
    logic [DIR_W-1:0] dir_z;
  } cfg_t;

  // One judged entity as it travels from the front to the back.
  typedef struct packed {
    logic             last;
    logic             cand;
    logic [LAT_W-1:0] lat;
    logic [NUM_W-1:0] num;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
  } judged_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/view_cone_nearest_target_pick_unit.sv]
// ----------------------------------------------------------------------------
// View cone nearest target pick unit
// Picks, per frame, the entity nearest to the view ray inside a narrow cone.
// ----------------------------------------------------------------------------
// The unit accepts one entity item in every clock cycle. Each item passes a
// six-stage measuring pipeline (offset, squares and projections, sums, range
// checks with the forward part squared, lateral part, cone test) and, if it
// is a candidate or closes the frame, enters a four-entry queue. The back end
// drains the queue at one item per cycle and keeps the candidate with the
// smallest lateral distance squared; on an exact tie the earlier entity stays.
// The frame result is loaded into the output register when its frame end is
// drained from the queue, and stays offered there until it is taken.
// Input stalls only when the queue is full, which happens when a result waits
// in the output register and a further frame end reaches the head of the
// queue behind it. Configuration writes take effect on the next cycle and
// must be made while no frame is in flight.
// ----------------------------------------------------------------------------
`include "view_cone_nearest_target_pick_unit_defines.svh"

module view_cone_nearest_target_pick_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [vcntp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vcntp_pkg::POS_W-1:0]     cfg_wdata_i,
  // Entity stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata from bit 0: entity_number[9:0], pos_x[20:0], pos_y[20:0], pos_z[20:0],
  // zero fill.
  input  logic [vcntp_pkg::TDATA_W-1:0]   s_axis_tdata,
  // tuser: entity_valid.
  input  logic                            s_axis_tuser,
  // tlast: last_item.
  input  logic                            s_axis_tlast,
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata from bit 0: focus_entity[9:0], focus_x[20:0], focus_y[20:0],
  // focus_z[20:0], zero fill.
  output logic [vcntp_pkg::TDATA_W-1:0]   m_axis_tdata,
  // tuser: found.
  output logic                            m_axis_tuser
);

  localparam int NB = vcntp_pkg::NUM_W;
  localparam int PB = vcntp_pkg::POS_W;

  vcntp_pkg::cfg_t      cfg_q;
  vcntp_pkg::judged_t   push_data;
  vcntp_pkg::judged_t   q_head;
  vcntp_pkg::q_status_t q_status;
  logic                 q_push;
  logic                 q_pop;
  logic [NB-1:0]        focus_entity;
  logic [PB-1:0]        focus_x, focus_y, focus_z;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.eye_x <= '0;
      cfg_q.eye_y <= '0;
      cfg_q.eye_z <= '0;
      cfg_q.dir_x <= vcntp_pkg::DIR_W'(16384);
      cfg_q.dir_y <= '0;
      cfg_q.dir_z <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vcntp_pkg::CFG_EYE_X: cfg_q.eye_x <= cfg_wdata_i;
        vcntp_pkg::CFG_EYE_Y: cfg_q.eye_y <= cfg_wdata_i;
        vcntp_pkg::CFG_EYE_Z: cfg_q.eye_z <= cfg_wdata_i;
        vcntp_pkg::CFG_DIR_X: cfg_q.dir_x <= cfg_wdata_i[vcntp_pkg::DIR_W-1:0];
        vcntp_pkg::CFG_DIR_Y: cfg_q.dir_y <= cfg_wdata_i[vcntp_pkg::DIR_W-1:0];
        vcntp_pkg::CFG_DIR_Z: cfg_q.dir_z <= cfg_wdata_i[vcntp_pkg::DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // The front measures and classifies every entity.
  vcntp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .num_i       (s_axis_tdata[NB-1:0]),
    .ent_valid_i (s_axis_tuser),
    .pos_x_i     (s_axis_tdata[NB+PB-1:NB]),
    .pos_y_i     (s_axis_tdata[NB+2*PB-1:NB+PB]),
    .pos_z_i     (s_axis_tdata[NB+3*PB-1:NB+2*PB]),
    .last_i      (s_axis_tlast),
    .push_o      (q_push),
    .push_data_o (push_data),
    .q_status_i  (q_status)
  );

  // Only candidates and frame ends are queued.
  vcntp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .status_o    (q_status)
  );

  // The back keeps the best candidate and produces the frame result.
  vcntp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (q_head),
    .q_status_i     (q_status),
    .pop_o          (q_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .found_o        (m_axis_tuser),
    .focus_entity_o (focus_entity),
    .focus_x_o      (focus_x),
    .focus_y_o      (focus_y),
    .focus_z_o      (focus_z)
  );

  assign m_axis_tdata = {(vcntp_pkg::TDATA_W - NB - 3 * PB)'(0),
                         focus_z, focus_y, focus_x, focus_entity};

  // The input is held off only while a queued item cannot be stored.
  `VCNTP_ASSERT_IMPLY(a_stall_only_when_full, s_axis_tvalid && !s_axis_tready, q_status.full)
  // Draining a frame end always loads a result.
  `VCNTP_ASSERT_NEXT(a_frame_end_loads_result, q_pop && q_head.last, m_axis_tvalid)
  // A not-found result carries all-zero data.
  `VCNTP_ASSERT_IMPLY(a_not_found_is_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)

endmodule

[rtl/vcntp_front.sv]
// ----------------------------------------------------------------------------
// View cone target pick: front
// Six-stage pipeline that measures each entity against the view ray and
// marks it as a candidate or not.
// ----------------------------------------------------------------------------
module vcntp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vcntp_pkg::cfg_t       cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [vcntp_pkg::NUM_W-1:0] num_i,
  input  logic                  ent_valid_i,
  input  logic [vcntp_pkg::POS_W-1:0] pos_x_i,
  input  logic [vcntp_pkg::POS_W-1:0] pos_y_i,
  input  logic [vcntp_pkg::POS_W-1:0] pos_z_i,
  input  logic                  last_i,
  output logic                  push_o,
  output vcntp_pkg::judged_t    push_data_o,
  input  vcntp_pkg::q_status_t  q_status_i
);

  typedef struct packed {
    logic                        last;
    logic [vcntp_pkg::NUM_W-1:0] num;
    logic [vcntp_pkg::POS_W-1:0] pos_x;
    logic [vcntp_pkg::POS_W-1:0] pos_y;
    logic [vcntp_pkg::POS_W-1:0] pos_z;
  } carry_t;

  localparam int STAGES = 6;

  logic [STAGES-1:0] v_q;
  carry_t            c_q [STAGES];
  logic [STAGES-1:0] ok_q;
  logic              en;
  logic              need_push;

  logic signed [vcntp_pkg::DELTA_W-1:0]  dx_d, dy_d, dz_d, dx_q, dy_q, dz_q;
  logic signed [2*vcntp_pkg::DELTA_W-1:0] px, py, pz;
  logic signed [vcntp_pkg::PROD_W-1:0]   fx_d, fy_d, fz_d, fx_q, fy_q, fz_q;
  logic [vcntp_pkg::SQ_W-1:0]            sx_q, sy_q, sz_q;
  logic [vcntp_pkg::DIST_W-1:0]          dist3_d, dist3_q, dist4_q, dist5_q;
  logic signed [vcntp_pkg::FWD_W-1:0]    fwd3_d, fwd3_q;
  logic [vcntp_pkg::FWD4_W-1:0]          fwd4;
  logic [vcntp_pkg::FSQ_W-1:0]           fsq_d, fsq_q;
  logic                                  keep4;
  logic [vcntp_pkg::LAT_W-1:0]           lat5_d, lat5_q, lat6_q;
  logic [vcntp_pkg::LAT100_W-1:0]        lat100;
  logic                                  cand6_d, cand6_q;

  assign need_push  = v_q[STAGES-1] && (cand6_q || c_q[STAGES-1].last);
  assign en         = !(need_push && q_status_i.full);
  assign in_ready_o = en;
  assign push_o     = need_push && !q_status_i.full;

  assign push_data_o.last  = c_q[STAGES-1].last;
  assign push_data_o.cand  = cand6_q;
  assign push_data_o.lat   = lat6_q;
  assign push_data_o.num   = c_q[STAGES-1].num;
  assign push_data_o.pos_x = c_q[STAGES-1].pos_x;
  assign push_data_o.pos_y = c_q[STAGES-1].pos_y;
  assign push_data_o.pos_z = c_q[STAGES-1].pos_z;

  // Stage 1: offsets from the eye.
  assign dx_d = $signed({pos_x_i[vcntp_pkg::POS_W-1], pos_x_i})
              - $signed({cfg_i.eye_x[vcntp_pkg::POS_W-1], cfg_i.eye_x});
  assign dy_d = $signed({pos_y_i[vcntp_pkg::POS_W-1], pos_y_i})
              - $signed({cfg_i.eye_y[vcntp_pkg::POS_W-1], cfg_i.eye_y});
  assign dz_d = $signed({pos_z_i[vcntp_pkg::POS_W-1], pos_z_i})
              - $signed({cfg_i.eye_z[vcntp_pkg::POS_W-1], cfg_i.eye_z});

  // Stage 2: squares and projections on the direction.
  assign px   = dx_q * dx_q;
  assign py   = dy_q * dy_q;
  assign pz   = dz_q * dz_q;
  assign fx_d = dx_q * $signed(cfg_i.dir_x);
  assign fy_d = dy_q * $signed(cfg_i.dir_y);
  assign fz_d = dz_q * $signed(cfg_i.dir_z);

  // Stage 3: sums.
  assign dist3_d = vcntp_pkg::DIST_W'(sx_q) + vcntp_pkg::DIST_W'(sy_q)
                 + vcntp_pkg::DIST_W'(sz_q);
  assign fwd3_d  = vcntp_pkg::FWD_W'(fx_q) + vcntp_pkg::FWD_W'(fy_q)
                 + vcntp_pkg::FWD_W'(fz_q);

  // Stage 4: range checks and the forward part squared.
  assign fwd4  = fwd3_q[vcntp_pkg::FWD_W-3:vcntp_pkg::FRAC_W];
  assign fsq_d = vcntp_pkg::FSQ_W'(fwd4) * vcntp_pkg::FSQ_W'(fwd4);
  assign keep4 = ok_q[2]
              && (dist3_q >= vcntp_pkg::DIST_W'(vcntp_pkg::NEAR_LIMIT))
              && !fwd3_q[vcntp_pkg::FWD_W-1] && (fwd3_q != '0);

  // Stage 5: lateral part squared, clamped at zero.
  assign lat5_d = (vcntp_pkg::FSQ_W'(dist4_q) > fsq_q)
                ? (dist4_q - fsq_q[vcntp_pkg::DIST_W-1:0]) : '0;

  // Stage 6: cone test, lateral squared times 100 against distance squared.
  assign lat100  = (vcntp_pkg::LAT100_W'(lat5_q) << 6)
                 + (vcntp_pkg::LAT100_W'(lat5_q) << 5)
                 + (vcntp_pkg::LAT100_W'(lat5_q) << 2);
  assign cand6_d = ok_q[4] && (lat100 <= vcntp_pkg::LAT100_W'(dist5_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q[0].last  <= last_i;
      c_q[0].num   <= num_i;
      c_q[0].pos_x <= pos_x_i;
      c_q[0].pos_y <= pos_y_i;
      c_q[0].pos_z <= pos_z_i;
      for (int i = 1; i < STAGES; i++) begin
        c_q[i] <= c_q[i-1];
      end
      ok_q[0] <= ent_valid_i && (vcntp_pkg::COUNT_CMP_W'(num_i)
                 < vcntp_pkg::COUNT_CMP_W'(vcntp_pkg::ENTITY_COUNT));
      ok_q[1] <= ok_q[0];
      ok_q[2] <= ok_q[1];
      ok_q[3] <= keep4;
      ok_q[4] <= ok_q[3];
      ok_q[5] <= cand6_d;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      dz_q    <= dz_d;
      sx_q    <= px[vcntp_pkg::SQ_W-1:0];
      sy_q    <= py[vcntp_pkg::SQ_W-1:0];
      sz_q    <= pz[vcntp_pkg::SQ_W-1:0];
      fx_q    <= fx_d;
      fy_q    <= fy_d;
      fz_q    <= fz_d;
      dist3_q <= dist3_d;
      fwd3_q  <= fwd3_d;
      dist4_q <= dist3_q;
      fsq_q   <= fsq_d;
      dist5_q <= dist4_q;
      lat5_q  <= lat5_d;
      lat6_q  <= lat5_q;
      cand6_q <= cand6_d;
    end
  end

endmodule

[rtl/vcntp_queue.sv]
// ----------------------------------------------------------------------------
// View cone target pick: queue
// Small first-in first-out buffer of judged entities between front and back.
// ----------------------------------------------------------------------------
module vcntp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  vcntp_pkg::judged_t   push_data_i,
  input  logic                 pop_i,
  output vcntp_pkg::judged_t   head_o,
  output vcntp_pkg::q_status_t status_o
);

  vcntp_pkg::judged_t mem_q [vcntp_pkg::QUEUE_DEPTH];
  logic [vcntp_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [vcntp_pkg::QCNT_W-1:0] cnt_q;
  logic                         do_pop;

  assign status_o.full  = (cnt_q == vcntp_pkg::QCNT_W'(vcntp_pkg::QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_q];
  assign do_pop         = pop_i && !status_o.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == vcntp_pkg::QPTR_W'(vcntp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == vcntp_pkg::QPTR_W'(vcntp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

[rtl/vcntp_back.sv]
// ----------------------------------------------------------------------------
// View cone target pick: back
// Keeps the candidate nearest to the view ray and emits the frame result.
// ----------------------------------------------------------------------------
module vcntp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vcntp_pkg::judged_t          head_i,
  input  vcntp_pkg::q_status_t        q_status_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [vcntp_pkg::NUM_W-1:0] focus_entity_o,
  output logic [vcntp_pkg::POS_W-1:0] focus_x_o,
  output logic [vcntp_pkg::POS_W-1:0] focus_y_o,
  output logic [vcntp_pkg::POS_W-1:0] focus_z_o
);

  logic                        have_q;
  logic [vcntp_pkg::LAT_W-1:0] best_lat_q;
  logic [vcntp_pkg::NUM_W-1:0] best_num_q;
  logic [vcntp_pkg::POS_W-1:0] best_x_q, best_y_q, best_z_q;
  logic                        out_valid_q;
  logic                        out_free;
  logic                        win;

  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_o       = !q_status_i.empty && (!head_i.last || out_free);
  // The first candidate always wins; later ones only when strictly nearer.
  assign win         = head_i.cand && (!have_q || (head_i.lat < best_lat_q));
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // A frame end is only drained once the output register is free.
      if (pop_o && head_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        if (head_i.last) begin
          have_q <= 1'b0;
        end else if (win) begin
          have_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && win && !head_i.last) begin
      best_lat_q <= head_i.lat;
      best_num_q <= head_i.num;
      best_x_q   <= head_i.pos_x;
      best_y_q   <= head_i.pos_y;
      best_z_q   <= head_i.pos_z;
    end
    if (pop_o && head_i.last) begin
      priority if (win) begin
        found_o        <= 1'b1;
        focus_entity_o <= head_i.num;
        focus_x_o      <= head_i.pos_x;
        focus_y_o      <= head_i.pos_y;
        focus_z_o      <= head_i.pos_z;
      end else if (have_q) begin
        found_o        <= 1'b1;
        focus_entity_o <= best_num_q;
        focus_x_o      <= best_x_q;
        focus_y_o      <= best_y_q;
        focus_z_o      <= best_z_q;
      end else begin
        found_o        <= 1'b0;
        focus_entity_o <= '0;
        focus_x_o      <= '0;
        focus_y_o      <= '0;
        focus_z_o      <= '0;
      end
    end
  end

endmodule
